### rtl/ppmi_pkg.sv
// Shared constants and types for the PPMI matrix transform block.
package ppmi_pkg;

  localparam int MAX_N         = 64;
  localparam int IDX_W         = $clog2(MAX_N);
  localparam int CELL_ADDR_W   = 2 * IDX_W;
  localparam int CELL_W        = 16;
  localparam int ROW_SUM_W     = CELL_W + IDX_W;
  localparam int GRAND_W       = CELL_W + 2 * IDX_W;
  localparam int PROD_W        = 2 * ROW_SUM_W;
  localparam int OUT_W         = 16;
  localparam int OUT_FRAC_BITS = 11;
  localparam int LOG_FRAC      = 28;
  localparam int Y_FRAC        = 30;
  localparam int K_W           = 6;
  localparam int L_W           = K_W + LOG_FRAC;
  localparam int LN2_W         = 30;
  localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261117;
  localparam int OUT_SHIFT     = LOG_FRAC + Y_FRAC - OUT_FRAC_BITS;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic                   rd;
    logic                   wr;
    logic [CELL_ADDR_W-1:0] cell_addr;
    logic [IDX_W-1:0]       row_addr;
    logic [IDX_W-1:0]       col_addr;
    logic [CELL_W-1:0]      cell_wdata;
    logic [ROW_SUM_W-1:0]   row_wdata;
    logic [ROW_SUM_W-1:0]   col_wdata;
  } mem_req_t;

endpackage

### rtl/ppmi_matrix_transform_core.sv
// Top level of the PPMI matrix transform: request handling and sums upkeep.
//
// Requests enter on the s_axis channel: tuser carries the action (write cell,
// read PPMI, clear), tdata carries row, column and value. Only a read makes a
// result, sent on m_axis with the PPMI in tdata and the undefined-ratio flag
// in tuser. One request is handled at a time and s_axis_tready is low while
// it is in work. A read uses the log unit only when the ratio is defined and
// above one: its normalizing loop finds k, the integer part of log2 of the
// ratio (k < 44), after which come the 30-step restoring divider and the 28
// square-and-compare steps. After reset the block sweeps the cell memory and
// both sum memories to zero, one cell a cycle, with s_axis_tready low. A
// clear request runs the same sweep. The result sits in an output register;
// while the receiver stalls, the next request is still taken and processed
// up to the point where its own result would have to be loaded.
module ppmi_matrix_transform_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // row[5:0], col[11:6], value[27:12], zero pad
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // ppmi[15:0]
  output logic        m_axis_tuser   // undefined_ratio
);
  import ppmi_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_CHECK, S_LOG, S_OUT
  } state_t;

  state_t                 state;
  logic [CELL_ADDR_W-1:0] sweep;
  logic [1:0]             action;
  logic [IDX_W-1:0]       row;
  logic [IDX_W-1:0]       col;
  logic [CELL_W-1:0]      value;
  logic [GRAND_W-1:0]     grand_total;
  logic [PROD_W-1:0]      num;
  logic [PROD_W-1:0]      den;
  logic                   m_nz;
  logic [OUT_W-1:0]       res;
  logic                   undef;
  logic                   log_start;

  mem_req_t               req;
  logic [CELL_W-1:0]      cell_rdata;
  logic [ROW_SUM_W-1:0]   row_rdata;
  logic [ROW_SUM_W-1:0]   col_rdata;
  logic                   log_done;
  logic [OUT_W-1:0]       log_result;
  logic                   accept;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    req = '0;
    case (state)
      S_CLEAR: begin
        req.wr        = 1'b1;
        req.cell_addr = sweep;
        req.row_addr  = sweep[IDX_W-1:0];
        req.col_addr  = sweep[IDX_W-1:0];
      end
      S_IDLE: begin
        req.rd        = accept;
        req.cell_addr = {s_axis_tdata[5:0], s_axis_tdata[11:6]};
        req.row_addr  = s_axis_tdata[5:0];
        req.col_addr  = s_axis_tdata[11:6];
      end
      S_LOOKUP: begin
        req.wr         = (action == ACT_WRITE);
        req.cell_addr  = {row, col};
        req.row_addr   = row;
        req.col_addr   = col;
        req.cell_wdata = value;
        req.row_wdata  = row_rdata - ROW_SUM_W'(cell_rdata) + ROW_SUM_W'(value);
        req.col_wdata  = col_rdata - ROW_SUM_W'(cell_rdata) + ROW_SUM_W'(value);
      end
      default: req = '0;
    endcase
  end

  ppmi_store u_store (
    .clk        (clk),
    .req        (req),
    .cell_rdata (cell_rdata),
    .row_rdata  (row_rdata),
    .col_rdata  (col_rdata)
  );

  ppmi_log u_log (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .num    (num),
    .den    (den),
    .done   (log_done),
    .result (log_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      sweep         <= '0;
      grand_total   <= '0;
      log_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          grand_total <= '0;
          sweep       <= sweep + 1'b1;
          if (&sweep) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            action <= s_axis_tuser;
            row    <= s_axis_tdata[5:0];
            col    <= s_axis_tdata[11:6];
            value  <= s_axis_tdata[27:12];
            case (s_axis_tuser)
              ACT_CLEAR: begin
                sweep <= '0;
                state <= S_CLEAR;
              end
              ACT_WRITE, ACT_READ: state <= S_LOOKUP;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_LOOKUP: begin
          if (action == ACT_WRITE) begin
            grand_total <= grand_total - GRAND_W'(cell_rdata) + GRAND_W'(value);
            state       <= S_IDLE;
          end else begin
            num   <= {{(PROD_W-GRAND_W){1'b0}}, grand_total} * cell_rdata;
            den   <= row_rdata * col_rdata;
            m_nz  <= |cell_rdata;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          undef <= (den == '0);
          res   <= '0;
          if (den != '0 && m_nz && num > den) begin
            log_start <= 1'b1;
            state     <= S_LOG;
          end else begin
            state <= S_OUT;
          end
        end
        S_LOG: begin
          log_start <= 1'b0;
          if (log_done) begin
            res   <= log_result;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res;
            m_axis_tuser  <= undef;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/ppmi_store.sv
// Cell, row-sum and column-sum memories with registered read data.
module ppmi_store (
  input  logic                           clk,
  input  ppmi_pkg::mem_req_t             req,
  output logic [ppmi_pkg::CELL_W-1:0]    cell_rdata,
  output logic [ppmi_pkg::ROW_SUM_W-1:0] row_rdata,
  output logic [ppmi_pkg::ROW_SUM_W-1:0] col_rdata
);
  import ppmi_pkg::*;

  logic [CELL_W-1:0]    cell_mem [MAX_N*MAX_N];
  logic [ROW_SUM_W-1:0] row_mem  [MAX_N];
  logic [ROW_SUM_W-1:0] col_mem  [MAX_N];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      cell_mem[req.cell_addr] <= req.cell_wdata;
      row_mem[req.row_addr]   <= req.row_wdata;
      col_mem[req.col_addr]   <= req.col_wdata;
    end
    if (req.rd) begin
      cell_rdata <= cell_mem[req.cell_addr];
      row_rdata  <= row_mem[req.row_addr];
      col_rdata  <= col_mem[req.col_addr];
    end
  end

endmodule

### rtl/ppmi_log.sv
// Iterative unit for clamped ln(num/den) in fixed point.
module ppmi_log (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ppmi_pkg::PROD_W-1:0] num,
  input  logic [ppmi_pkg::PROD_W-1:0] den,
  output logic                        done,
  output logic [ppmi_pkg::OUT_W-1:0]  result
);
  import ppmi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_DIV, S_SQ_MUL, S_SQ_CHK, S_LN_MUL, S_LN_ADD
  } state_t;

  localparam int HALF_W = L_W / 2;

  state_t                    state;
  logic [PROD_W-1:0]         num_r;
  logic [PROD_W-1:0]         d;
  logic [PROD_W-1:0]         rem;
  logic [K_W-1:0]            k;
  logic [Y_FRAC-1:0]         frac;
  logic [4:0]                cnt;
  logic [Y_FRAC:0]           y;
  logic [2*Y_FRAC+1:0]       sq;
  logic [LOG_FRAC-1:0]       l2;
  logic [L_W-HALF_W+LN2_W-1:0] p_hi;
  logic [HALF_W+LN2_W-1:0]   p_lo;

  logic [PROD_W:0]    d_dbl;
  logic [PROD_W:0]    rem_s;
  logic               take;
  logic [Y_FRAC-1:0]  frac_next;
  logic [Y_FRAC+1:0]  sq_top;
  logic [L_W-1:0]     l_full;
  logic [63:0]        prod;
  logic [63:0]        shifted;

  always_comb begin
    d_dbl     = {d, 1'b0};
    rem_s     = {rem, 1'b0};
    take      = rem_s >= {1'b0, d};
    frac_next = {frac[Y_FRAC-2:0], take};
    sq_top    = sq[2*Y_FRAC+1:Y_FRAC];
    l_full    = {k, l2};
    prod      = (64'(p_hi) << HALF_W) + 64'(p_lo);
    shifted   = prod >> OUT_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_LN_ADD);
      case (state)
        S_IDLE: begin
          if (start) begin
            num_r <= num;
            d     <= den;
            k     <= '0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // Align the divisor so that the quotient lies in [1,2).
          if (d_dbl <= {1'b0, num_r}) begin
            d <= d_dbl[PROD_W-1:0];
            k <= k + 1'b1;
          end else begin
            rem   <= num_r - d;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= take ? PROD_W'(rem_s - {1'b0, d}) : rem_s[PROD_W-1:0];
          frac <= frac_next;
          if (cnt == 5'(Y_FRAC - 1)) begin
            y     <= {1'b1, frac_next};
            cnt   <= '0;
            state <= S_SQ_MUL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SQ_MUL: begin
          sq    <= y * y;
          state <= S_SQ_CHK;
        end
        S_SQ_CHK: begin
          // A square at or above 2.0 yields a one bit and is halved.
          y   <= sq_top[Y_FRAC+1] ? sq_top[Y_FRAC+1:1] : sq_top[Y_FRAC:0];
          l2  <= {l2[LOG_FRAC-2:0], sq_top[Y_FRAC+1]};
          cnt <= cnt + 1'b1;
          if (cnt == 5'(LOG_FRAC - 1)) state <= S_LN_MUL;
          else state <= S_SQ_MUL;
        end
        S_LN_MUL: begin
          p_hi  <= l_full[L_W-1:HALF_W] * LN2_Q30;
          p_lo  <= l_full[HALF_W-1:0] * LN2_Q30;
          state <= S_LN_ADD;
        end
        S_LN_ADD: begin
          result <= (|shifted[63:OUT_W]) ? {OUT_W{1'b1}} : shifted[OUT_W-1:0];
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/ppmi_checker.sv
// Port-level checker for the PPMI matrix transform, bound to the top level.
module ppmi_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import ppmi_pkg::*;

  // A held result keeps its value until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // An undefined ratio always reports a zero PPMI.
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("undefined ratio with nonzero ppmi");

  // Only one request of real work is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready &&
      (s_axis_tuser == ACT_WRITE || s_axis_tuser == ACT_READ ||
       s_axis_tuser == ACT_CLEAR) |=> !s_axis_tready)
    else $error("request taken while another is in work");

  // A write or a clear never brings out a new result right after it.
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready &&
      (s_axis_tuser == ACT_WRITE || s_axis_tuser == ACT_CLEAR) |=> !$rose(m_axis_tvalid))
    else $error("result without a read");

endmodule

bind ppmi_matrix_transform_core ppmi_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
